[rtl/core/edm_pkg.sv]
// ---------------------------------------------------------------------------
// edm_pkg
// Shared types and constants for the edit distance engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edm_pkg;

  localparam int MaxLenDefault = 64;
  localparam int OpW           = 2;
  localparam int SymW          = 8;
  localparam int DistW         = 7;
  localparam int DistMax       = 127;

  typedef enum logic [OpW-1:0] {
    OP_FIRST   = 2'd0,
    OP_SECOND  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_CELL,
    ST_WAIT
  } state_t;

  // text store controls
  typedef struct packed {
    logic wr_first;
    logic wr_second;
    logic rd_first;
    logic rd_second;
  } text_cmd_t;

  // cost row controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } cost_cmd_t;

endpackage

`default_nettype wire

[rtl/core/edm_text_mem.sv]
// ---------------------------------------------------------------------------
// edm_text_mem
// Two byte stores for the first and second strings, one read port each.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edm_text_mem #(
  parameter int MaxLen = edm_pkg::MaxLenDefault,
  localparam int AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1
) (
  input  wire logic                    clk,
  input  wire edm_pkg::text_cmd_t      cmd,
  input  wire logic [AddrW-1:0]        wr_addr,
  input  wire logic [edm_pkg::SymW-1:0] wr_data,
  input  wire logic [AddrW-1:0]        first_rd_addr,
  input  wire logic [AddrW-1:0]        second_rd_addr,
  output logic      [edm_pkg::SymW-1:0] first_rd_data,
  output logic      [edm_pkg::SymW-1:0] second_rd_data
);

  logic [edm_pkg::SymW-1:0] first_text  [MaxLen];
  logic [edm_pkg::SymW-1:0] second_text [MaxLen];

  always_ff @(posedge clk) begin
    if (cmd.wr_first) begin
      first_text[wr_addr] <= wr_data;
    end
    if (cmd.rd_first) begin
      first_rd_data <= first_text[first_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_second) begin
      second_text[wr_addr] <= wr_data;
    end
    if (cmd.rd_second) begin
      second_rd_data <= second_text[second_rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/edm_cost_mem.sv]
// ---------------------------------------------------------------------------
// edm_cost_mem
// Single cost row of the distance table; entry k holds column k+1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edm_cost_mem #(
  parameter int MaxLen = edm_pkg::MaxLenDefault,
  localparam int AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1,
  localparam int LenW  = $clog2(MaxLen + 1)
) (
  input  wire logic               clk,
  input  wire edm_pkg::cost_cmd_t cmd,
  input  wire logic [AddrW-1:0]   wr_addr,
  input  wire logic [LenW-1:0]    wr_data,
  input  wire logic [AddrW-1:0]   rd_addr,
  output logic      [LenW-1:0]    rd_data
);

  logic [LenW-1:0] cost_row [MaxLen];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      cost_row[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= cost_row[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/edm_seq.sv]
// ---------------------------------------------------------------------------
// edm_seq
// Load/compute sequencer: appends, row walk of the recurrence, result reg.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edm_seq #(
  parameter int MaxLen = edm_pkg::MaxLenDefault,
  localparam int AddrW = (MaxLen > 1) ? $clog2(MaxLen) : 1,
  localparam int LenW  = $clog2(MaxLen + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // request side
  input  wire logic                     in_valid,
  input  wire logic [edm_pkg::OpW-1:0]  in_op,
  input  wire logic [edm_pkg::SymW-1:0] in_sym,
  output logic                          in_ready,
  // result side
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic      [edm_pkg::DistW-1:0] out_dist,
  output logic                          out_trunc,
  // text store
  output edm_pkg::text_cmd_t            text_cmd,
  output logic      [AddrW-1:0]         text_wr_addr,
  output logic      [edm_pkg::SymW-1:0] text_wr_data,
  output logic      [AddrW-1:0]         first_rd_addr,
  output logic      [AddrW-1:0]         second_rd_addr,
  input  wire logic [edm_pkg::SymW-1:0] first_rd_data,
  input  wire logic [edm_pkg::SymW-1:0] second_rd_data,
  // cost row
  output edm_pkg::cost_cmd_t            cost_cmd,
  output logic      [AddrW-1:0]         cost_wr_addr,
  output logic      [LenW-1:0]          cost_wr_data,
  output logic      [AddrW-1:0]         cost_rd_addr,
  input  wire logic [LenW-1:0]          cost_rd_data
);

  localparam int SatW = (LenW > edm_pkg::DistW) ? LenW : edm_pkg::DistW;

  edm_pkg::state_t state_r, state_nxt;
  logic [LenW-1:0] first_len_r, first_len_nxt;
  logic [LenW-1:0] second_len_r, second_len_nxt;
  logic            ovf_r, ovf_nxt;
  logic [LenW-1:0] i_r, i_nxt;
  logic [LenW-1:0] j_r, j_nxt;
  logic [LenW-1:0] diag_r, diag_nxt;
  logic [LenW-1:0] left_r, left_nxt;
  logic [LenW-1:0] result_r, result_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [edm_pkg::DistW-1:0] out_dist_r, out_dist_nxt;
  logic            out_trunc_r, out_trunc_nxt;

  logic [LenW-1:0] j_m1;
  logic [LenW-1:0] i_m1;
  logic [LenW-1:0] min_dl;
  logic [LenW-1:0] min_all;
  logic [LenW-1:0] cell_val;
  logic [SatW-1:0] res_ext;
  logic [edm_pkg::DistW-1:0] dist_sat;

  // one cell of the recurrence
  always_comb begin
    j_m1     = j_r - LenW'(1);
    i_m1     = i_r - LenW'(1);
    min_dl   = (diag_r < left_r) ? diag_r : left_r;
    min_all  = (min_dl < cost_rd_data) ? min_dl : cost_rd_data;
    cell_val = (first_rd_data == second_rd_data) ? diag_r : (min_all + LenW'(1));
    res_ext  = SatW'(result_r);
    dist_sat = (res_ext > SatW'(edm_pkg::DistMax)) ? edm_pkg::DistW'(edm_pkg::DistMax)
                                                    : res_ext[edm_pkg::DistW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= edm_pkg::ST_IDLE;
      first_len_r  <= '0;
      second_len_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_len_r  <= first_len_nxt;
      second_len_r <= second_len_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    diag_r      <= diag_nxt;
    left_r      <= left_nxt;
    result_r    <= result_nxt;
    out_dist_r  <= out_dist_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    first_len_nxt  = first_len_r;
    second_len_nxt = second_len_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    diag_nxt       = diag_r;
    left_nxt       = left_r;
    result_nxt     = result_r;
    out_dist_nxt   = out_dist_r;
    out_trunc_nxt  = out_trunc_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    in_ready       = 1'b0;
    text_cmd       = '0;
    text_wr_addr   = (in_op == edm_pkg::OP_FIRST) ? first_len_r[AddrW-1:0]
                                                  : second_len_r[AddrW-1:0];
    text_wr_data   = in_sym;
    first_rd_addr  = i_m1[AddrW-1:0];
    second_rd_addr = '0;
    cost_cmd       = '0;
    cost_wr_addr   = j_m1[AddrW-1:0];
    cost_wr_data   = cell_val;
    cost_rd_addr   = '0;

    unique case (state_r)
      edm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (edm_pkg::op_t'(in_op))
            edm_pkg::OP_FIRST: begin
              if (first_len_r < LenW'(MaxLen)) begin
                text_cmd.wr_first = 1'b1;
                first_len_nxt     = first_len_r + LenW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            edm_pkg::OP_SECOND: begin
              if (second_len_r < LenW'(MaxLen)) begin
                text_cmd.wr_second = 1'b1;
                second_len_nxt     = second_len_r + LenW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            edm_pkg::OP_COMPUTE: begin
              if (first_len_r == '0 || second_len_r == '0) begin
                // one side empty: distance is the other length
                result_nxt = first_len_r | second_len_r;
                state_nxt  = edm_pkg::ST_WAIT;
              end else begin
                j_nxt     = LenW'(1);
                state_nxt = edm_pkg::ST_INIT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      edm_pkg::ST_INIT: begin
        // row zero: cost[j] = j
        cost_cmd.wr_en = 1'b1;
        cost_wr_data   = j_r;
        if (j_r == second_len_r) begin
          i_nxt     = LenW'(1);
          state_nxt = edm_pkg::ST_ROW;
        end else begin
          j_nxt = j_r + LenW'(1);
        end
      end

      edm_pkg::ST_ROW: begin
        // fetch row symbol and first column; column zero is i
        text_cmd.rd_first  = 1'b1;
        text_cmd.rd_second = 1'b1;
        cost_cmd.rd_en     = 1'b1;
        diag_nxt           = i_m1;
        left_nxt           = i_r;
        j_nxt              = LenW'(1);
        state_nxt          = edm_pkg::ST_CELL;
      end

      edm_pkg::ST_CELL: begin
        cost_cmd.wr_en = 1'b1;
        left_nxt       = cell_val;
        diag_nxt       = cost_rd_data;
        if (j_r != second_len_r) begin
          text_cmd.rd_second = 1'b1;
          cost_cmd.rd_en     = 1'b1;
          second_rd_addr     = j_r[AddrW-1:0];
          cost_rd_addr       = j_r[AddrW-1:0];
          j_nxt              = j_r + LenW'(1);
        end else if (i_r != first_len_r) begin
          i_nxt     = i_r + LenW'(1);
          state_nxt = edm_pkg::ST_ROW;
        end else begin
          result_nxt = cell_val;
          state_nxt  = edm_pkg::ST_WAIT;
        end
      end

      edm_pkg::ST_WAIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_dist_nxt   = dist_sat;
          out_trunc_nxt  = ovf_r;
          first_len_nxt  = '0;
          second_len_nxt = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = edm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = edm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_dist  = out_dist_r;
  assign out_trunc = out_trunc_r;

endmodule

`default_nettype wire

[rtl/core/edit_distance_engine.sv]
// ---------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein distance (unit costs) over two byte strings loaded by requests.
// ---------------------------------------------------------------------------
// Requests carry an op in in_tuser: append in_tdata to the first string,
// append to the second string, or compute. Each string holds up to MAX_LEN
// bytes; further appends are dropped and flagged in the next result's
// truncated bit (out_tuser). A compute emits one result and clears both
// strings. A compute with lengths m, n > 0 first seeds the cost row, then
// for each row fetches the row symbol and then walks its cells one at a time,
// bounded by the single read/write port pair of the cost-row memory. With
// an empty string a compute skips the walk and reports the other length.
// Distances above 127 (MAX_LEN > 127) saturate.
// Appends are accepted while a finished result waits on out_tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edit_distance_engine #(
  parameter int MAX_LEN = edm_pkg::MaxLenDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // request channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] symbol
  input  wire logic [1:0] in_tuser,   // [1:0] op
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] distance, [7] zero
  output logic [0:0]      out_tuser   // [0] truncated
);

  localparam int AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LenW  = $clog2(MAX_LEN + 1);

  edm_pkg::text_cmd_t            text_cmd;
  logic [AddrW-1:0]              text_wr_addr;
  logic [edm_pkg::SymW-1:0]      text_wr_data;
  logic [AddrW-1:0]              first_rd_addr;
  logic [AddrW-1:0]              second_rd_addr;
  logic [edm_pkg::SymW-1:0]      first_rd_data;
  logic [edm_pkg::SymW-1:0]      second_rd_data;
  edm_pkg::cost_cmd_t            cost_cmd;
  logic [AddrW-1:0]              cost_wr_addr;
  logic [LenW-1:0]               cost_wr_data;
  logic [AddrW-1:0]              cost_rd_addr;
  logic [LenW-1:0]               cost_rd_data;
  logic [edm_pkg::DistW-1:0]     out_dist;
  logic                          out_trunc;

  // sequencer: owns lengths, overflow flag, row/column counters, result reg
  edm_seq #(.MaxLen(MAX_LEN)) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_op          (in_tuser),
    .in_sym         (in_tdata),
    .in_ready       (in_tready),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_dist       (out_dist),
    .out_trunc      (out_trunc),
    .text_cmd       (text_cmd),
    .text_wr_addr   (text_wr_addr),
    .text_wr_data   (text_wr_data),
    .first_rd_addr  (first_rd_addr),
    .second_rd_addr (second_rd_addr),
    .first_rd_data  (first_rd_data),
    .second_rd_data (second_rd_data),
    .cost_cmd       (cost_cmd),
    .cost_wr_addr   (cost_wr_addr),
    .cost_wr_data   (cost_wr_data),
    .cost_rd_addr   (cost_rd_addr),
    .cost_rd_data   (cost_rd_data)
  );

  // string bytes; first-string read data holds for a whole row
  edm_text_mem #(.MaxLen(MAX_LEN)) u_text (
    .clk            (clk),
    .cmd            (text_cmd),
    .wr_addr        (text_wr_addr),
    .wr_data        (text_wr_data),
    .first_rd_addr  (first_rd_addr),
    .second_rd_addr (second_rd_addr),
    .first_rd_data  (first_rd_data),
    .second_rd_data (second_rd_data)
  );

  // cost row: cell j is read in the cycle before its write-back; the write of
  // column j never collides with the read of column j+1
  edm_cost_mem #(.MaxLen(MAX_LEN)) u_cost (
    .clk     (clk),
    .cmd     (cost_cmd),
    .wr_addr (cost_wr_addr),
    .wr_data (cost_wr_data),
    .rd_addr (cost_rd_addr),
    .rd_data (cost_rd_data)
  );

  assign out_tdata = {1'b0, out_dist};
  assign out_tuser = out_trunc;

  // text appends and cost-row walk never overlap
  a_no_append_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (text_cmd.wr_first || text_cmd.wr_second) |-> !cost_cmd.wr_en)
    else $error("text append while cost row is being written");

  // only one string is appended per request
  a_single_append: assert property (@(posedge clk) disable iff (!rst_n)
    !(text_cmd.wr_first && text_cmd.wr_second))
    else $error("both strings written in one cycle");

  // every cost read pairs with a second-string read of the same column
  a_cost_text_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    cost_cmd.rd_en |-> (text_cmd.rd_second && cost_rd_addr == second_rd_addr))
    else $error("cost row read out of step with second string");

  // a new result is only loaded from the busy (non-accepting) state
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid && !out_tready)) |-> $past(!in_tready))
    else $error("result appeared while accepting requests");

endmodule

`default_nettype wire
